/* design/pclp_pkg.sv */
`timescale 1ns / 1ps
// Package for the pixel command line parser.
// Holds the payload structs, result codes, widths and character helpers.
// No dependencies.
package pclp_pkg;

	localparam int COORD_BITS = 12;
	localparam int REG_BITS = 13;
	localparam int ACC_BITS = COORD_BITS + 1;
	localparam int CMP_BITS = (ACC_BITS > REG_BITS) ? ACC_BITS : REG_BITS;
	localparam logic [REG_BITS-1:0] WIDTH_RESET = REG_BITS'(64);
	localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(32);
	localparam logic [ACC_BITS-1:0] COORD_LIMIT = ACC_BITS'(1) << COORD_BITS;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_X = 8'h58;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_SIZE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       new_connection;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            result_kind;
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
		logic [REG_BITS-1:0]   reply_width;
		logic [REG_BITS-1:0]   reply_height;
	} res_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Returns the nibble in the low bits and a valid flag in bit 4.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			r = {1'b1, c[3:0]};
		end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [ACC_BITS-1:0] add_digit(input logic [ACC_BITS-1:0] acc,
			input logic [3:0] d);
		logic [ACC_BITS+3:0] a;
		logic [ACC_BITS+3:0] v;
		a = {4'b0000, acc};
		v = (a << 3) + (a << 1) + {{ACC_BITS{1'b0}}, d};
		if (v > {4'b0000, COORD_LIMIT}) begin
			v = {4'b0000, COORD_LIMIT};
		end
		return v[ACC_BITS-1:0];
	endfunction

endpackage

/* design/pixel_command_line_parser.sv */
`timescale 1ns / 1ps
// Top level of the pixel command line parser: input register, line parser
// and result register. Depends on pclp_pkg.

// Takes one command byte per cycle while cmd_stall is low, and emits at most
// one result per line, at the line feed: a pixel write for "PX x y rrggbb", a
// size reply for "SIZE", or an error that closes the connection until a byte
// arrives with new_connection set. A byte passes through the input register
// and the result register, and a stalled result holds both; the parser state
// is updated from the input register, which allows one byte per cycle while
// res_stall is low. Configuration writes take effect at once, so they belong
// in a quiet period with no byte or result in flight.
module pixel_command_line_parser
	import pclp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cmd_t                cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output res_t                res,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [REG_BITS-1:0] cfg_data
);

	typedef enum logic [3:0] {
		PH_START, PH_S1, PH_S2, PH_S3, PH_SIZE, PH_P1, PH_P2, PH_XSP,
		PH_X, PH_YST, PH_Y, PH_HEX, PH_TAIL, PH_BAD, PH_CLOSED
	} phase_t;

	logic [REG_BITS-1:0] width_q;
	logic [REG_BITS-1:0] height_q;
	logic                valid_s1;
	cmd_t                cmd_s1;
	phase_t              phase_q, phase_d, phase_c;
	logic [ACC_BITS-1:0] ax_q, ax_d, ax_c;
	logic [ACC_BITS-1:0] ay_q, ay_d, ay_c;
	logic [23:0]         rgb_q, rgb_d, rgb_c;
	logic [2:0]          hc_q, hc_d, hc_c;
	logic                emit_d;
	res_t                res_d;
	logic                fire_s1;
	logic [7:0]          c;
	logic [4:0]          hx;
	logic                x_ok, y_ok;

	assign fire_s1 = valid_s1 && (!res_valid || !res_stall);
	assign cmd_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	assign c = cmd_s1.rx_byte;
	assign hx = hex_nibble(c);
	assign x_ok = !ax_c[COORD_BITS] && (CMP_BITS'(ax_c) < CMP_BITS'(width_q));
	assign y_ok = !ay_c[COORD_BITS] && (CMP_BITS'(ay_c) < CMP_BITS'(height_q));

	always_comb begin
		if (cmd_s1.new_connection) begin
			phase_c = PH_START;
			ax_c = '0;
			ay_c = '0;
			rgb_c = '0;
			hc_c = '0;
		end else begin
			phase_c = phase_q;
			ax_c = ax_q;
			ay_c = ay_q;
			rgb_c = rgb_q;
			hc_c = hc_q;
		end
		phase_d = phase_c;
		ax_d = ax_c;
		ay_d = ay_c;
		rgb_d = rgb_c;
		hc_d = hc_c;
		emit_d = 1'b0;
		res_d = '0;
		if (phase_c == PH_CLOSED) begin
			phase_d = PH_CLOSED;
		end else if (c == CH_LF) begin
			emit_d = 1'b1;
			phase_d = PH_START;
			ax_d = '0;
			ay_d = '0;
			rgb_d = '0;
			hc_d = '0;
			if (phase_c == PH_SIZE) begin
				res_d.result_kind = KIND_SIZE;
				res_d.reply_width = width_q;
				res_d.reply_height = height_q;
			end else if (phase_c == PH_TAIL && x_ok && y_ok) begin
				res_d.result_kind = KIND_PIXEL;
				res_d.pixel_x = ax_c[COORD_BITS-1:0];
				res_d.pixel_y = ay_c[COORD_BITS-1:0];
				res_d.red = rgb_c[23:16];
				res_d.green = rgb_c[15:8];
				res_d.blue = rgb_c[7:0];
			end else begin
				res_d.result_kind = KIND_ERROR;
				phase_d = PH_CLOSED;
			end
		end else begin
			case (phase_c)
				PH_START: phase_d = (c == CH_S) ? PH_S1 : (c == CH_P) ? PH_P1 : PH_BAD;
				PH_S1:    phase_d = (c == CH_I) ? PH_S2 : PH_BAD;
				PH_S2:    phase_d = (c == CH_Z) ? PH_S3 : PH_BAD;
				PH_S3:    phase_d = (c == CH_E) ? PH_SIZE : PH_BAD;
				PH_P1:    phase_d = (c == CH_X) ? PH_P2 : PH_BAD;
				PH_P2:    phase_d = (c == CH_SPACE) ? PH_XSP : PH_BAD;
				PH_XSP: begin
					if (is_dec(c)) begin
						ax_d = add_digit('0, c[3:0]);
						phase_d = PH_X;
					end else if (c != CH_SPACE) begin
						phase_d = PH_BAD;
					end
				end
				PH_X: begin
					if (is_dec(c)) begin
						ax_d = add_digit(ax_c, c[3:0]);
					end else begin
						phase_d = (c == CH_SPACE) ? PH_YST : PH_BAD;
					end
				end
				PH_YST: begin
					if (is_dec(c)) begin
						ay_d = add_digit('0, c[3:0]);
						phase_d = PH_Y;
					end else begin
						phase_d = PH_BAD;
					end
				end
				PH_Y: begin
					if (is_dec(c)) begin
						ay_d = add_digit(ay_c, c[3:0]);
					end else if (c == CH_SPACE) begin
						phase_d = PH_HEX;
						hc_d = '0;
						rgb_d = '0;
					end else begin
						phase_d = PH_BAD;
					end
				end
				PH_HEX: begin
					if (!hx[4]) begin
						phase_d = PH_BAD;
					end else begin
						rgb_d = {rgb_c[19:0], hx[3:0]};
						hc_d = hc_c + 3'd1;
						if (hc_c == 3'd5) begin
							phase_d = PH_TAIL;
						end
					end
				end
				PH_SIZE, PH_TAIL, PH_BAD: phase_d = phase_c;
				default:  phase_d = PH_BAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			ax_q <= '0;
			ay_q <= '0;
			rgb_q <= '0;
			hc_q <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			ax_q <= ax_d;
			ay_q <= ay_d;
			rgb_q <= rgb_d;
			hc_q <= hc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (fire_s1) begin
			res_valid <= emit_d;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_d) begin
			res <= res_d;
		end
	end

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !cmd_stall)
		else $error("Input stalled while the input register is empty.");

	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && emit_d && res_d.result_kind == KIND_ERROR) |=> phase_q == PH_CLOSED)
		else $error("Error result did not close the connection.");

	a_pixel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.result_kind == KIND_PIXEL) |->
		(CMP_BITS'(res.pixel_x) < CMP_BITS'(width_q)))
		else $error("Pixel write column outside the panel.");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.result_kind == KIND_PIXEL) || (res.result_kind == KIND_SIZE)
		|| (res.result_kind == KIND_ERROR)))
		else $error("Result carries an unused kind code.");

endmodule
